// ----- hdl/mlpds_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, trained weights and table builders for the dijet score network.
// No dependencies; used by mlp_dijet_score_core.
package mlpds_pkg;

   localparam int SIG_TABLE_DEPTH_DEF  = 1024;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   localparam int NUM_WEIGHTS = 191;
   localparam int L1_NEURONS  = 15;
   localparam int L1_INPUTS   = 6;
   localparam int L2_NEURONS  = 5;
   localparam int L2_BASE     = 105;
   localparam int OUT_BASE    = 185;
   localparam int FEAT_W      = 26;
   localparam int ACT_W       = 16;

   localparam longint unsigned Q30        = 64'd1 << 30;
   localparam longint unsigned EXP_M1_Q30 = 64'd395007542;

   // output scaling: score = floor(t / 49), t = floor(y * 50 / 2^frac)
   localparam int T_W          = 22;
   localparam int CAP_T        = 49 * 65536;
   localparam int DIV49_SHIFT  = 28;
   localparam int DIV49_MUL_W  = 23;
   localparam int DIV49_MUL    = ((2 ** 28) + 48) / 49;
   localparam logic [15:0] SCORE_MAX = 16'hFFFF;

   function automatic longint p0(input longint m);
      return m * 10000;
   endfunction
   function automatic longint p1(input longint m);
      return m * 1000;
   endfunction
   function automatic longint p2(input longint m);
      return m * 100;
   endfunction
   function automatic longint p3(input longint m);
      return m * 10;
   endfunction
   function automatic longint p4(input longint m);
      return m;
   endfunction

   // decimal weights in units of 1e-10: layer 1 (15 x [bias,6]),
   // layer 2 (5 x [bias,15]), output ([bias,5])
   localparam longint DEC_W [NUM_WEIGHTS] = '{
      p1(3401877), p1(-1056171), p1(2830992), p1(2984400), p1(4116473), p1(-3024486),
      p1(-1647772),
      p1(2686068), p1(-2222253), p2(9109838), p4(4124089), p1(1299482), p1(-1341908),
      p2(-6297962),
      p1(4522297), p1(4161951), p1(1357117), p1(2172969), p1(-3583975), p1(1069689),
      p1(-4836994),
      p1(-2571132), p1(-3627684), p1(3041767), p1(-3433209), p2(-9905560), p1(-3702095),
      p1(-3911912),
      p1(4989245), p1(-2817431), p2(1292617), p1(3391084), p1(1126397), p1(-2039686),
      p1(1375673),
      p2(2428719), p3(-6415707), p1(4727750), p1(-2074832), p1(2713577), p2(2674546),
      p1(2699139),
      p2(-9977138), p1(3915294), p1(-2166853), p1(-1475417), p1(3077245), p1(4190265),
      p1(-4302447),
      p1(4493271), p2(2599535), p1(-4139442), p1(-3077862), p1(1632269), p1(3902326),
      p1(-1511071),
      p1(-4361163), p1(-4419279), p2(-4473301), p1(-4376293), p1(-2604143), p1(5240741),
      p1(4011090),
      p1(3173292), p1(-2241760), p1(-6317291), p1(-2830620), p1(1750255), p2(-4006414),
      p1(2725541),
      p2(3396690), p1(-4485282), p2(-1537250), p1(4377254), p1(4355614), p1(3298911),
      p1(-1948187),
      p2(8802536), p2(-1645690), p2(-3593754), p1(-3300631), p1(1853030), p2(1364193),
      p1(6227304),
      p1(3295576), p2(-4563790), p1(-2571594), p1(3939400), p1(-1492818), p1(3167820),
      p1(4563062),
      p1(1007358), p3(-4626892), p3(9315815), p1(-1653549), p1(6544170), p3(-1062288),
      p1(1809237),
      p1(1842185), p1(4109720), p2(-1750934), p1(-2841750), p1(4502524), p1(4201283),
      p1(-3523400),
      p1(4840965), p1(1042806), p1(-1559401), p1(2621663), p1(-2558055), p1(2465964),
      p2(-5264297), p2(8963995),
      p2(-9445861), p1(-2836257), p2(-2444416), p1(4221516), p1(-1707438), p1(-1831930),
      p1(6496654), p1(-2541290),
      p1(-3759727), p3(3201696), p1(2814706), p1(4590240), p1(4426849), p1(2079947),
      p1(-1268005), p1(2240432),
      p1(-1648751), p1(-2282312), p1(-3116120), p2(1741257), p1(-1827420), p1(-3576361),
      p1(1537631), p1(-4002528),
      p1(3328196), p1(-3241346), p1(2649351), p1(-3956927), p1(4618675), p1(-4378990),
      p2(4913286), p1(-2940118),
      p1(-2419236), p1(3560494), p2(8887588), p1(1189877), p1(5520993), p1(1662827),
      p1(2030284), p1(-3767420),
      p1(-3021794), p2(2426857), p1(-4206145), p1(-3557886), p1(-2914001), p2(-4993384),
      p1(3783907), p1(1474936),
      p1(3256811), p1(-3321865), p1(-3979840), p1(5148389), p1(-4002522), p1(4484992),
      p1(-3581619), p1(5721040),
      p1(-4385875), p1(3705718), p1(-4430307), p1(-4508402), p1(4231011), p2(5637889),
      p1(-3123048), p1(-2918703),
      p2(-6334352), p1(4725171), p1(3391282), p1(-1324763), p2(-7793628), p2(8607008),
      p2(7129920), p1(2323856),
      p0(-6035074), p0(-6215130), p0(4345867), p0(5610218), p0(6488374), p0(5429897)
   };

   typedef longint wq_type [NUM_WEIGHTS];

   // round to nearest, ties away from zero
   function automatic longint quant(input longint c, input int wfb);
      longint unsigned mag;
      mag = (c < 0) ? longint'(-c) : longint'(c);
      mag = ((mag << wfb) + 64'd5000000000) / 64'd10000000000;
      return (c < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic wq_type build_wq(input int wfb);
      wq_type w;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
         w[i] = quant(DEC_W[i], wfb);
      end
      return w;
   endfunction

   // shift-subtract divide, elaboration only
   function automatic longint unsigned udiv64(input longint unsigned n,
                                              input longint unsigned d);
      longint unsigned q;
      longint unsigned rem;
      q   = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem  = rem - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid at the midpoint of bin i of 2^ld bins over [-16, 16)
   function automatic logic [15:0] sigmoid_entry(input int i, input int ld);
      longint m;
      longint unsigned am, u, n, f, term, r, den, s;
      m    = 2 * longint'(i) + 1 - (longint'(1) << ld);
      am   = (m < 0) ? longint'(-m) : longint'(m);
      u    = (am << 34) >> ld;
      n    = u >> 30;
      f    = u & (Q30 - 64'd1);
      term = Q30;
      r    = Q30;
      for (int k = 1; k <= 12; k++) begin
         term = udiv64((term * f) >> 30, longint'(k));
         if ((k & 1) != 0) r = r - term;
         else              r = r + term;
      end
      for (longint unsigned j = 0; j < n; j++) begin
         r = (r * EXP_M1_Q30) >> 30;
      end
      den = Q30 + r;
      if (m >= 0) s = udiv64((64'd1 << 46) + (den >> 1), den);
      else        s = udiv64((r << 16) + (den >> 1), den);
      return (s > 64'd65535) ? SCORE_MAX : s[15:0];
   endfunction

endpackage

// ----- hdl/mlpds_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlpds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ----- hdl/mlpds_sig_lut.sv -----
`timescale 1ns / 1ps
// Sigmoid lookup: saturate a neuron sum, register the bin index, read the table RAM.
// Depends on mlpds_ram.
module mlpds_sig_lut #(
   parameter int ACC_W = 46,
   parameter int FRAC  = 28,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [ACC_W-1:0]  acc,
   input  logic                     fill_we,
   input  logic [$clog2(DEPTH)-1:0] fill_addr,
   input  logic [15:0]              fill_data,
   output logic [15:0]              sig
);

   localparam int LD = $clog2(DEPTH);
   localparam int SH = FRAC + 5 - LD;
   localparam logic signed [ACC_W-1:0] LIM = ACC_W'(64'sd1 <<< (FRAC + 4));

   logic signed [ACC_W-1:0] shifted;
   logic [LD-1:0]           idx_in;
   logic [LD-1:0]           idx_ff;

   // clamp to [-16, 16), then take the top bits of the offset sum
   always_comb begin
      shifted = acc + LIM;
      priority if (acc < -LIM) begin
         idx_in = '0;
      end else if (acc >= LIM) begin
         idx_in = '1;
      end else begin
         idx_in = LD'(shifted >>> SH);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff <= idx_in;
      end
   end

   mlpds_ram #(
      .WIDTH(16),
      .DEPTH(DEPTH)
   ) u_tab (
      .clock(clock),
      .we   (fill_we),
      .waddr(fill_addr),
      .wdata(fill_data),
      .re   (advance),
      .raddr(idx_ff),
      .rdata(sig)
   );

endmodule

// ----- hdl/mlp_dijet_score_core.sv -----
`timescale 1ns / 1ps
// Top level of the dijet score network: 6-15-5-1 fixed-point perceptron pipeline.
// Depends on mlpds_pkg and mlpds_sig_lut (which holds mlpds_ram).
//
// Usage:
//   Input channel req_*: one word of six dijet features per handshake.
//   Result channel rsp_*: one score word per input word, in order.
//   Throughput: one word per cycle, sustained, once the tables are loaded and while the output queue is not full.
//   The pipeline has fifteen register stages: feature capture, layer-1 products,
//   two adder levels, sigmoid index and table read, layer-2 products, two adder
//   levels, index and table read, output products, output sum, scaling and the
//   divide-by-49 product. Each sigmoid lookup is its own RAM copy, read once a cycle while not stalled.
//   Reset: after reset drops, the sigmoid table is copied into the lookup RAMs;
//   req_ready stays low during that pass.
//   Stall: a two-word output queue follows the pipeline. While it is full the
//   whole pipeline holds, and req_ready drops; nothing is lost or repeated.
module mlp_dijet_score_core #(
   parameter int SIG_TABLE_DEPTH  = mlpds_pkg::SIG_TABLE_DEPTH_DEF,
   parameter int WEIGHT_FRAC_BITS = mlpds_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_pt_lead,
   input  logic [15:0]        req_pt_sub,
   input  logic [11:0]        req_eta_gap,
   input  logic [13:0]        req_phi_gap,
   input  logic [15:0]        req_pair_mass,
   input  logic signed [13:0] req_eta_product,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_score
);

   localparam int LD  = $clog2(SIG_TABLE_DEPTH);
   localparam int W   = WEIGHT_FRAC_BITS;
   localparam int WB  = W + 1;
   localparam int WO  = W + 4;
   localparam int P1W = WB + mlpds_pkg::FEAT_W;
   localparam int A1  = WB + 29;
   localparam int P2W = WB + mlpds_pkg::ACT_W + 1;
   localparam int P3W = WO + mlpds_pkg::ACT_W + 1;
   localparam int A2  = WB + 21;
   localparam int YW  = A2 + 6;
   localparam int TFW = YW - W;
   localparam int PW  = mlpds_pkg::T_W + mlpds_pkg::DIV49_MUL_W;
   localparam int NST = 15;

   localparam mlpds_pkg::wq_type WQ = mlpds_pkg::build_wq(W);

   typedef logic [15:0] sig_tab_type [SIG_TABLE_DEPTH];

   function automatic sig_tab_type build_sig_tab();
      sig_tab_type t;
      for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
         t[i] = mlpds_pkg::sigmoid_entry(i, LD);
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

   // hidden-layer weights stay below one in magnitude
   function automatic logic signed [WB-1:0] wgt(input int k);
      return WB'(WQ[k]);
   endfunction

   // output weights reach about 6.5, so they carry three more integer bits
   function automatic logic signed [WO-1:0] wgt_out(input int k);
      return WO'(WQ[k]);
   endfunction

   // ---------------------------------------------------------------- table load
   logic [LD:0]   fill_cnt_ff, fill_cnt_in;
   logic          fill_we_ff;
   logic [LD-1:0] fill_addr_ff;
   logic [15:0]   fill_data_ff;
   logic          fill_done;

   assign fill_cnt_in = fill_cnt_ff + (LD + 1)'(1);
   assign fill_done   = fill_cnt_ff[LD] & ~fill_we_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         fill_we_ff  <= 1'b0;
      end else begin
         fill_we_ff <= ~fill_cnt_ff[LD];
         if (!fill_cnt_ff[LD]) begin
            fill_cnt_ff <= fill_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_addr_ff <= fill_cnt_ff[LD-1:0];
      fill_data_ff <= SIG_TAB[fill_cnt_ff[LD-1:0]];
   end

   // ---------------------------------------------------------------- flow control
   logic             adv;
   logic [NST:1]     valid_ff;
   logic [1:0]       out_cnt_ff;
   logic [15:0]      out_d_ff [2];
   logic             push, pop;
   logic [15:0]      score_w;

   // advance all stages unless the output queue is full
   assign adv       = (out_cnt_ff != 2'd2);
   assign req_ready = adv & fill_done;
   assign push      = adv & valid_ff[NST];
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (out_cnt_ff != 2'd0);
   assign rsp_score = out_d_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-1:1], req_valid & req_ready};
      end
   end

   // ---------------------------------------------------------------- stage 1: features
   logic signed [mlpds_pkg::FEAT_W-1:0] feat_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         feat_ff[0] <= {2'b0, req_pt_lead, 8'b0};
         feat_ff[1] <= {2'b0, req_pt_sub, 8'b0};
         feat_ff[2] <= {10'b0, req_eta_gap, 4'b0};
         feat_ff[3] <= {12'b0, req_phi_gap};
         feat_ff[4] <= {1'b0, req_pair_mass, 9'b0};
         feat_ff[5] <= {{8{req_eta_product[13]}}, req_eta_product, 4'b0};
      end
   end

   // ---------------------------------------------------------------- stages 2-4: layer 1
   logic signed [P1W-1:0] p1_in [15][6];
   logic signed [P1W-1:0] p1_ff [15][6];
   logic signed [A1-1:0]  g1_in [15][2];
   logic signed [A1-1:0]  g1_ff [15][2];
   logic signed [A1-1:0]  a1_ff [15];

   always_comb begin
      for (int i = 0; i < mlpds_pkg::L1_NEURONS; i++) begin
         for (int j = 0; j < mlpds_pkg::L1_INPUTS; j++) begin
            p1_in[i][j] = wgt(i * 7 + j + 1) * feat_ff[j];
         end
      end
   end

   always_comb begin
      logic signed [A1-1:0] bias;
      for (int i = 0; i < mlpds_pkg::L1_NEURONS; i++) begin
         bias        = A1'(wgt(i * 7)) <<< 12;
         g1_in[i][0] = bias + A1'(p1_ff[i][0]) + A1'(p1_ff[i][1]) + A1'(p1_ff[i][2]);
         g1_in[i][1] = A1'(p1_ff[i][3]) + A1'(p1_ff[i][4]) + A1'(p1_ff[i][5]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= p1_in;
         g1_ff <= g1_in;
         for (int i = 0; i < mlpds_pkg::L1_NEURONS; i++) begin
            a1_ff[i] <= g1_ff[i][0] + g1_ff[i][1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 5-6: sigmoid 1
   logic [15:0] h1 [15];

   for (genvar gi = 0; gi < mlpds_pkg::L1_NEURONS; gi++) begin : g_l1_sig
      mlpds_sig_lut #(
         .ACC_W(A1),
         .FRAC (W + 12),
         .DEPTH(SIG_TABLE_DEPTH)
      ) u_sig (
         .clock    (clock),
         .advance  (adv),
         .acc      (a1_ff[gi]),
         .fill_we  (fill_we_ff),
         .fill_addr(fill_addr_ff),
         .fill_data(fill_data_ff),
         .sig      (h1[gi])
      );
   end

   // ---------------------------------------------------------------- stages 7-9: layer 2
   logic signed [P2W-1:0] p2_in [5][15];
   logic signed [P2W-1:0] p2_ff [5][15];
   logic signed [A2-1:0]  g2_in [5][4];
   logic signed [A2-1:0]  g2_ff [5][4];
   logic signed [A2-1:0]  a2_ff [5];

   always_comb begin
      for (int i = 0; i < mlpds_pkg::L2_NEURONS; i++) begin
         for (int j = 0; j < mlpds_pkg::L1_NEURONS; j++) begin
            p2_in[i][j] = wgt(mlpds_pkg::L2_BASE + i * 16 + j + 1) * $signed({1'b0, h1[j]});
         end
      end
   end

   always_comb begin
      logic signed [A2-1:0] bias;
      for (int i = 0; i < mlpds_pkg::L2_NEURONS; i++) begin
         bias        = A2'(wgt(mlpds_pkg::L2_BASE + i * 16)) <<< 16;
         g2_in[i][0] = bias + A2'(p2_ff[i][0]) + A2'(p2_ff[i][1]) + A2'(p2_ff[i][2]);
         g2_in[i][1] = A2'(p2_ff[i][3]) + A2'(p2_ff[i][4]) + A2'(p2_ff[i][5])
                     + A2'(p2_ff[i][6]);
         g2_in[i][2] = A2'(p2_ff[i][7]) + A2'(p2_ff[i][8]) + A2'(p2_ff[i][9])
                     + A2'(p2_ff[i][10]);
         g2_in[i][3] = A2'(p2_ff[i][11]) + A2'(p2_ff[i][12]) + A2'(p2_ff[i][13])
                     + A2'(p2_ff[i][14]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff <= p2_in;
         g2_ff <= g2_in;
         for (int i = 0; i < mlpds_pkg::L2_NEURONS; i++) begin
            a2_ff[i] <= g2_ff[i][0] + g2_ff[i][1] + g2_ff[i][2] + g2_ff[i][3];
         end
      end
   end

   // ---------------------------------------------------------------- stages 10-11: sigmoid 2
   logic [15:0] h2 [5];

   for (genvar gi = 0; gi < mlpds_pkg::L2_NEURONS; gi++) begin : g_l2_sig
      mlpds_sig_lut #(
         .ACC_W(A2),
         .FRAC (W + 16),
         .DEPTH(SIG_TABLE_DEPTH)
      ) u_sig (
         .clock    (clock),
         .advance  (adv),
         .acc      (a2_ff[gi]),
         .fill_we  (fill_we_ff),
         .fill_addr(fill_addr_ff),
         .fill_data(fill_data_ff),
         .sig      (h2[gi])
      );
   end

   // ---------------------------------------------------------------- stages 12-15: output
   logic signed [P3W-1:0] p3_ff [5];
   logic signed [A2-1:0]  y_in, y_ff;
   logic signed [YW-1:0]  y50;
   logic [TFW-1:0]        t_full;
   logic [mlpds_pkg::T_W-1:0] t_ff;
   logic                  zero_ff, cap_ff;
   logic [PW-1:0]         prod_ff;
   logic                  zero2_ff, cap2_ff;

   always_comb begin
      y_in = A2'(wgt_out(mlpds_pkg::OUT_BASE)) <<< 16;
      for (int j = 0; j < mlpds_pkg::L2_NEURONS; j++) begin
         y_in = y_in + A2'(p3_ff[j]);
      end
   end

   // y * 50 as shifts and adds; keep every integer bit so the cap sees large sums
   always_comb begin
      y50    = (YW'(y_ff) <<< 5) + (YW'(y_ff) <<< 4) + (YW'(y_ff) <<< 1);
      t_full = y50[YW-1:W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < mlpds_pkg::L2_NEURONS; j++) begin
            p3_ff[j] <= wgt_out(mlpds_pkg::OUT_BASE + j + 1) * $signed({1'b0, h2[j]});
         end
         y_ff     <= y_in;
         t_ff     <= t_full[mlpds_pkg::T_W-1:0];
         zero_ff  <= (y_ff <= 0);
         cap_ff   <= (t_full >= TFW'(mlpds_pkg::CAP_T));
         prod_ff  <= PW'(t_ff) * PW'(mlpds_pkg::DIV49_MUL);
         zero2_ff <= zero_ff;
         cap2_ff  <= cap_ff;
      end
   end

   always_comb begin
      priority if (zero2_ff) begin
         score_w = '0;
      end else if (cap2_ff) begin
         score_w = mlpds_pkg::SCORE_MAX;
      end else begin
         score_w = prod_ff[mlpds_pkg::DIV49_SHIFT+15:mlpds_pkg::DIV49_SHIFT];
      end
   end

   // ---------------------------------------------------------------- output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         unique case ({push, pop})
            2'b10:   out_cnt_ff <= out_cnt_ff + 2'd1;
            2'b01:   out_cnt_ff <= out_cnt_ff - 2'd1;
            default: out_cnt_ff <= out_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case ({push, pop})
         2'b10: begin
            if (out_cnt_ff == 2'd0) out_d_ff[0] <= score_w;
            else                    out_d_ff[1] <= score_w;
         end
         2'b01: begin
            out_d_ff[0] <= out_d_ff[1];
         end
         2'b11: begin
            if (out_cnt_ff == 2'd1) out_d_ff[0] <= score_w;
            else begin
               out_d_ff[0] <= out_d_ff[1];
               out_d_ff[1] <= score_w;
            end
         end
         default: begin
            out_d_ff[0] <= out_d_ff[0];
         end
      endcase
   end

   // ---------------------------------------------------------------- checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      $rose(fill_done) |-> (valid_ff == '0) && (out_cnt_ff == 2'd0))
      else $error("word in flight before table load finished");

   a_zero_score: assert property (@(posedge clock) disable iff (reset)
      push && zero2_ff |-> score_w == 16'd0)
      else $error("non-positive sum gave nonzero score");

   a_cap_score: assert property (@(posedge clock) disable iff (reset)
      push && cap2_ff && !zero2_ff |-> score_w == mlpds_pkg::SCORE_MAX)
      else $error("saturated sum not capped");

endmodule
